/* hw/rtl/integer_instruction_execute_macros.svh */
// Assertion macros shared by the execute unit.
`ifndef INTEGER_INSTRUCTION_EXECUTE_MACROS_SVH
`define INTEGER_INSTRUCTION_EXECUTE_MACROS_SVH

// Checked only outside reset.
`define IIE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define IIE_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* hw/rtl/iie_pkg.sv */
// Types, opcodes and constants of the integer execute unit.
package iie_pkg;

   localparam int NUM_REGS = 32;
   localparam int RegIdxW  = $clog2(NUM_REGS);
   localparam logic [4:0] LINK_REG = 5'd31;

   typedef logic [5:0]  op_type;
   typedef logic [5:0]  func_type;
   typedef logic [4:0]  reg_num_type;
   typedef logic [15:0] imm_short_type;
   typedef logic [25:0] imm_long_type;
   typedef logic [31:0] word_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_HALT,
      ST_ILLEGAL,
      ST_UNSUP
   } status_type;

   // set-compare kinds, taken from the low three bits of the code
   typedef enum logic [2:0] {
      CMP_EQ,
      CMP_NE,
      CMP_LT,
      CMP_GT,
      CMP_LE,
      CMP_GE
   } cmp_kind_type;

   // primary opcodes
   localparam op_type OP_RTYPE = 6'd0;
   localparam op_type OP_FLOAT = 6'd1;
   localparam op_type OP_J     = 6'd2;
   localparam op_type OP_JAL   = 6'd3;
   localparam op_type OP_BEQZ  = 6'd4;
   localparam op_type OP_BNEZ  = 6'd5;
   localparam op_type OP_ADDI  = 6'd8;
   localparam op_type OP_ADDUI = 6'd9;
   localparam op_type OP_SUBI  = 6'd10;
   localparam op_type OP_SUBUI = 6'd11;
   localparam op_type OP_ANDI  = 6'd12;
   localparam op_type OP_ORI   = 6'd13;
   localparam op_type OP_XORI  = 6'd14;
   localparam op_type OP_LHI   = 6'd15;
   localparam op_type OP_RFE   = 6'd16;
   localparam op_type OP_TRAP  = 6'd17;
   localparam op_type OP_JR    = 6'd18;
   localparam op_type OP_JALR  = 6'd19;
   localparam op_type OP_SLLI  = 6'd20;
   localparam op_type OP_SRLI  = 6'd22;
   localparam op_type OP_SRAI  = 6'd23;
   localparam op_type OP_SEQI  = 6'd24;
   localparam op_type OP_SNEI  = 6'd25;
   localparam op_type OP_SLTI  = 6'd26;
   localparam op_type OP_SGTI  = 6'd27;
   localparam op_type OP_SLEI  = 6'd28;
   localparam op_type OP_SGEI  = 6'd29;
   localparam op_type OP_LB    = 6'd32;
   localparam op_type OP_LH    = 6'd33;
   localparam op_type OP_LW    = 6'd35;
   localparam op_type OP_LBU   = 6'd36;
   localparam op_type OP_LHU   = 6'd37;
   localparam op_type OP_SB    = 6'd40;
   localparam op_type OP_SH    = 6'd41;
   localparam op_type OP_SW    = 6'd43;
   localparam op_type OP_SEQUI = 6'd48;
   localparam op_type OP_SNEUI = 6'd49;
   localparam op_type OP_SLTUI = 6'd50;
   localparam op_type OP_SGTUI = 6'd51;
   localparam op_type OP_SLEUI = 6'd52;
   localparam op_type OP_SGEUI = 6'd53;

   // R-format function codes
   localparam func_type FN_NOP    = 6'd0;
   localparam func_type FN_HALT   = 6'd1;
   localparam func_type FN_WAIT   = 6'd2;
   localparam func_type FN_SLL    = 6'd4;
   localparam func_type FN_SRL    = 6'd6;
   localparam func_type FN_SRA    = 6'd7;
   localparam func_type FN_SEQU   = 6'd16;
   localparam func_type FN_SNEU   = 6'd17;
   localparam func_type FN_SLTU   = 6'd18;
   localparam func_type FN_SGTU   = 6'd19;
   localparam func_type FN_SLEU   = 6'd20;
   localparam func_type FN_SGEU   = 6'd21;
   localparam func_type FN_ADD    = 6'd32;
   localparam func_type FN_ADDU   = 6'd33;
   localparam func_type FN_SUB    = 6'd34;
   localparam func_type FN_SUBU   = 6'd35;
   localparam func_type FN_AND    = 6'd36;
   localparam func_type FN_OR     = 6'd37;
   localparam func_type FN_XOR    = 6'd38;
   localparam func_type FN_SEQ    = 6'd40;
   localparam func_type FN_SNE    = 6'd41;
   localparam func_type FN_SLT    = 6'd42;
   localparam func_type FN_SGT    = 6'd43;
   localparam func_type FN_SLE    = 6'd44;
   localparam func_type FN_SGE    = 6'd45;
   localparam func_type FN_MOVI2S = 6'd48;
   localparam func_type FN_MOVS2I = 6'd49;

endpackage

/* hw/rtl/iie_if.sv */
// Request and response channel interfaces of the integer execute unit.
interface iie_req_if;
   import iie_pkg::*;

   logic          valid;
   logic          ready;
   op_type        op;
   func_type      func;
   reg_num_type   reg_a;
   reg_num_type   reg_b;
   reg_num_type   reg_c;
   imm_short_type imm_short;
   imm_long_type  imm_long;
   word_type      pc;

   modport source (
      output valid, op, func, reg_a, reg_b, reg_c, imm_short, imm_long, pc,
      input  ready
   );
   modport sink (
      input  valid, op, func, reg_a, reg_b, reg_c, imm_short, imm_long, pc,
      output ready
   );
endinterface

interface iie_rsp_if;
   import iie_pkg::*;

   logic        valid;
   logic        ready;
   word_type    next_pc;
   logic        write_enable;
   reg_num_type write_reg;
   word_type    write_value;
   status_type  status;

   modport source (
      output valid, next_pc, write_enable, write_reg, write_value, status,
      input  ready
   );
   modport sink (
      input  valid, next_pc, write_enable, write_reg, write_value, status,
      output ready
   );
endinterface

/* hw/rtl/integer_instruction_execute.sv */
// Integer execute unit: register file, ALU, branch and jump resolution.
// A request is registered with its register-file reads, then its result in the response
// register; one instruction per cycle unless the response stalls. The register-file write of an
// instruction is forwarded into the operands of the instruction read in the same cycle.
// Reset clears the register-file valid bits at once, so every register reads zero after reset.
module integer_instruction_execute (
   input logic   clock,
   input logic   reset,
   iie_req_if.sink   req_bus,
   iie_rsp_if.source rsp_bus
);
   import iie_pkg::*;

   // register file storage plus per-entry valid bits
   word_type            rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_vld_ff;

   // execute stage
   logic          s1_valid_ff;
   op_type        s1_op_ff;
   func_type      s1_func_ff;
   reg_num_type   s1_reg_a_ff;
   reg_num_type   s1_reg_b_ff;
   reg_num_type   s1_reg_c_ff;
   imm_short_type s1_imm_short_ff;
   imm_long_type  s1_imm_long_ff;
   word_type      s1_pc_ff;
   word_type      rd_a_ff;
   word_type      rd_b_ff;
   logic          vld_a_ff;
   logic          vld_b_ff;
   logic          byp_a_ff;
   logic          byp_b_ff;
   word_type      byp_val_ff;

   // response register
   logic        rsp_valid_ff;
   word_type    rsp_next_pc_ff;
   logic        rsp_we_ff;
   reg_num_type rsp_reg_ff;
   word_type    rsp_value_ff;
   status_type  rsp_status_ff;

   logic        req_ready;
   logic        req_xfer;
   logic        out_adv;
   logic        byp_a_in;
   logic        byp_b_in;

   word_type    opa;
   word_type    opb;
   word_type    simm;
   word_type    zimm;
   word_type    slong;
   word_type    npc;
   word_type    val;
   logic        wr;
   reg_num_type dst;
   status_type  st;
   logic        wr_final;
   reg_num_type dst_final;
   word_type    val_final;

   function automatic logic in_range(reg_num_type r);
      return {1'b0, r} < 6'(NUM_REGS);
   endfunction

   function automatic word_type setcmp(logic [2:0] code, word_type x, word_type y,
                                       logic uns);
      logic lt;
      logic gt;
      logic r;
      lt = uns ? (x < y) : ($signed(x) < $signed(y));
      gt = uns ? (x > y) : ($signed(x) > $signed(y));
      case (cmp_kind_type'(code))
         CMP_EQ:  r = (x == y);
         CMP_NE:  r = (x != y);
         CMP_LT:  r = lt;
         CMP_GT:  r = gt;
         CMP_LE:  r = !gt;
         default: r = !lt;
      endcase
      return {31'b0, r};
   endfunction

   // handshake
   assign out_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_ready = !s1_valid_ff || out_adv;
   assign req_xfer  = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   // the write leaving the execute stage lands at the same edge as the new read
   assign byp_a_in = out_adv && wr_final && (dst_final == req_bus.reg_a);
   assign byp_b_in = out_adv && wr_final && (dst_final == req_bus.reg_b);

   always_ff @(posedge clock) begin
      if (out_adv && wr_final) begin
         rf_mem[dst_final[RegIdxW-1:0]] <= val_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (out_adv && wr_final) begin
         rf_vld_ff[dst_final[RegIdxW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_a_ff  <= rf_mem[req_bus.reg_a[RegIdxW-1:0]];
         rd_b_ff  <= rf_mem[req_bus.reg_b[RegIdxW-1:0]];
         vld_a_ff <= rf_vld_ff[req_bus.reg_a[RegIdxW-1:0]];
         vld_b_ff <= rf_vld_ff[req_bus.reg_b[RegIdxW-1:0]];
         byp_val_ff      <= val_final;
         s1_op_ff        <= req_bus.op;
         s1_func_ff      <= req_bus.func;
         s1_reg_a_ff     <= req_bus.reg_a;
         s1_reg_b_ff     <= req_bus.reg_b;
         s1_reg_c_ff     <= req_bus.reg_c;
         s1_imm_short_ff <= req_bus.imm_short;
         s1_imm_long_ff  <= req_bus.imm_long;
         s1_pc_ff        <= req_bus.pc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_a_ff    <= 1'b0;
         byp_b_ff    <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
         byp_a_ff    <= byp_a_in;
         byp_b_ff    <= byp_b_in;
      end else if (out_adv) begin
         s1_valid_ff <= 1'b0;
         byp_a_ff    <= 1'b0;
         byp_b_ff    <= 1'b0;
      end
   end

   // operand select: register zero and out-of-range numbers read zero
   always_comb begin
      opa = '0;
      opb = '0;
      if (s1_reg_a_ff != '0 && in_range(s1_reg_a_ff)) begin
         opa = byp_a_ff ? byp_val_ff : (vld_a_ff ? rd_a_ff : '0);
      end
      if (s1_reg_b_ff != '0 && in_range(s1_reg_b_ff)) begin
         opb = byp_b_ff ? byp_val_ff : (vld_b_ff ? rd_b_ff : '0);
      end
   end

   assign simm  = {{16{s1_imm_short_ff[15]}}, s1_imm_short_ff};
   assign zimm  = {16'b0, s1_imm_short_ff};
   assign slong = {{6{s1_imm_long_ff[25]}}, s1_imm_long_ff};

   always_comb begin
      npc = s1_pc_ff;
      wr  = 1'b1;
      val = '0;
      st  = ST_OK;
      dst = s1_reg_b_ff;
      if (s1_op_ff == OP_RTYPE) begin
         dst = s1_reg_c_ff;
         case (s1_func_ff)
            FN_NOP, FN_WAIT: wr = 1'b0;
            FN_HALT: begin
               wr = 1'b0;
               st = ST_HALT;
            end
            FN_SLL: val = opa << opb[4:0];
            FN_SRL: val = opa >> opb[4:0];
            FN_SRA: val = word_type'($signed(opa) >>> opb[4:0]);
            FN_SEQU, FN_SNEU, FN_SLTU, FN_SGTU, FN_SLEU, FN_SGEU:
               val = setcmp(s1_func_ff[2:0], opa, opb, 1'b1);
            FN_ADD, FN_ADDU: val = opa + opb;
            FN_SUB, FN_SUBU: val = opa - opb;
            FN_AND: val = opa & opb;
            FN_OR:  val = opa | opb;
            FN_XOR: val = opa ^ opb;
            FN_SEQ, FN_SNE, FN_SLT, FN_SGT, FN_SLE, FN_SGE:
               val = setcmp(s1_func_ff[2:0], opa, opb, 1'b0);
            FN_MOVI2S, FN_MOVS2I: begin
               wr = 1'b0;
               st = ST_UNSUP;
            end
            default: begin
               wr = 1'b0;
               st = ST_ILLEGAL;
            end
         endcase
      end else begin
         case (s1_op_ff)
            OP_FLOAT, OP_RFE, OP_TRAP, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
            OP_SB, OP_SH, OP_SW: begin
               wr = 1'b0;
               st = ST_UNSUP;
            end
            OP_J: begin
               wr  = 1'b0;
               npc = s1_pc_ff + slong;
            end
            OP_JAL: begin
               dst = LINK_REG;
               val = s1_pc_ff;
               npc = s1_pc_ff + slong;
            end
            OP_BEQZ: begin
               wr = 1'b0;
               if (opa == '0) npc = s1_pc_ff + simm;
            end
            OP_BNEZ: begin
               wr = 1'b0;
               if (opa != '0) npc = s1_pc_ff + simm;
            end
            OP_ADDI, OP_ADDUI: val = opa + simm;
            OP_SUBI, OP_SUBUI: val = opa - simm;
            OP_ANDI: val = opa & simm;
            OP_ORI:  val = opa | simm;
            OP_XORI: val = opa ^ simm;
            OP_LHI:  val = {s1_imm_short_ff, 16'b0};
            OP_JR: begin
               wr  = 1'b0;
               npc = opa;
            end
            OP_JALR: begin
               dst = LINK_REG;
               val = s1_pc_ff;
               npc = opa;
            end
            OP_SLLI: val = opa << s1_imm_short_ff[4:0];
            OP_SRLI: val = opa >> s1_imm_short_ff[4:0];
            OP_SRAI: val = word_type'($signed(opa) >>> s1_imm_short_ff[4:0]);
            OP_SEQI, OP_SNEI, OP_SLTI, OP_SGTI, OP_SLEI, OP_SGEI:
               val = setcmp(s1_op_ff[2:0], opa, simm, 1'b0);
            OP_SEQUI, OP_SNEUI, OP_SLTUI, OP_SGTUI, OP_SLEUI, OP_SGEUI:
               val = setcmp(s1_op_ff[2:0], opa, zimm, 1'b1);
            default: begin
               wr = 1'b0;
               st = ST_ILLEGAL;
            end
         endcase
      end
   end

   // writes to register zero or past the file are dropped and reported as none
   assign wr_final  = wr && (dst != '0) && in_range(dst);
   assign dst_final = wr_final ? dst : '0;
   assign val_final = wr_final ? val : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_next_pc_ff <= npc;
         rsp_we_ff      <= wr_final;
         rsp_reg_ff     <= dst_final;
         rsp_value_ff   <= val_final;
         rsp_status_ff  <= st;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.next_pc      = rsp_next_pc_ff;
   assign rsp_bus.write_enable = rsp_we_ff;
   assign rsp_bus.write_reg    = rsp_reg_ff;
   assign rsp_bus.write_value  = rsp_value_ff;
   assign rsp_bus.status       = rsp_status_ff;

`include "integer_instruction_execute_macros.svh"

   `IIE_ASSERT_RST(a_reset_clears_rsp, reset |=> !rsp_bus.valid, "response valid after reset")
   `IIE_ASSERT(a_no_write_r0, rsp_bus.valid && rsp_bus.write_enable |-> rsp_bus.write_reg != '0, "write to register zero reported")
   `IIE_ASSERT(a_fault_no_write, rsp_bus.valid && rsp_bus.status != ST_OK |-> !rsp_bus.write_enable, "register write on halt or fault")
   `IIE_ASSERT(a_bypass_needs_item, byp_a_ff || byp_b_ff |-> s1_valid_ff, "forwarding flag without an instruction in execute")

endmodule
